// ----- sv/rdlh_pkg.sv -----
// Shared types, sizes and helpers for the reuse-distance histogram core.
// Used by the cell, the stack row, the tally stage and the top level.
package rdlh_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int NUM_BUCKETS = 16;
    localparam int ADDR_BITS   = 48;

    localparam int SHIFT_W     = 4;
    localparam int LEVEL_W_OUT = 4;
    localparam int CNT_W       = 32;
    localparam int POS_W       = $clog2(STACK_DEPTH + 1);
    localparam int LVL_W       = (NUM_BUCKETS > 2) ? $clog2(NUM_BUCKETS) : 1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    typedef logic [ADDR_BITS-1:0] tag_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [LVL_W-1:0]     lvl_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // One lookup in flight along the row of cells.
    typedef struct packed {
        logic valid;
        tag_t search_tag;
        tag_t carry_tag;
        logic carry_valid;
        logic hit;
        pos_t pos;
    } slot_t;

    // Bit length of the stack position, clipped to the last bucket.
    function automatic lvl_t level_of(input pos_t pos);
        int len;
        len = 0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (pos[i])
            begin
                len = i + 1;
            end
        end
        if (len > NUM_BUCKETS - 1)
        begin
            len = NUM_BUCKETS - 1;
        end
        return LVL_W'(len);
    endfunction

    function automatic cnt_t sat_inc(input cnt_t x);
        return (x == CNT_MAX) ? x : x + cnt_t'(1);
    endfunction

endpackage

// ----- sv/rdlh_cell.sv -----
// One entry of the recency stack plus its pipeline slot register.
// Depends on rdlh_pkg for slot_t and tag widths.
module rdlh_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  rdlh_pkg::slot_t slot_in,
    output rdlh_pkg::slot_t slot_out
);
    import rdlh_pkg::*;

    tag_t  tag_reg;
    logic  valid_reg;
    slot_t slot_reg;

    tag_t  tag_next;
    logic  valid_next;
    slot_t slot_next;
    logic  match;
    logic  take;

    assign match = valid_reg && (tag_reg == slot_in.search_tag);
    assign take  = slot_in.valid && !slot_in.hit;

    always_comb
    begin
        slot_next  = slot_in;
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (take)
        begin
            // swap the carried entry in, pass the old one down
            tag_next              = slot_in.carry_tag;
            valid_next            = slot_in.carry_valid;
            slot_next.carry_tag   = tag_reg;
            slot_next.carry_valid = valid_reg;
            if (match)
            begin
                slot_next.hit = 1'b1;
            end
            else
            begin
                slot_next.pos = slot_in.pos + pos_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (advance)
        begin
            tag_reg   <= tag_next;
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ----- sv/rdlh_stack.sv -----
// Row of recency-stack cells, most recent entry at cell 0.
// Depends on rdlh_pkg and rdlh_cell.
module rdlh_stack (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  rdlh_pkg::slot_t head,
    output rdlh_pkg::slot_t tail
);
    import rdlh_pkg::*;

    slot_t link [0:STACK_DEPTH];

    assign link[0] = head;

    for (genvar k = 0; k < STACK_DEPTH; k++)
    begin : g_cell
        rdlh_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .slot_in  (link[k]),
            .slot_out (link[k+1])
        );
    end

    assign tail = link[STACK_DEPTH];

endmodule

// ----- sv/rdlh_tally.sv -----
// Histogram, unique-line counter and result register at the end of the row.
// Depends on rdlh_pkg for level_of, sat_inc and counter widths.
module rdlh_tally (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  rdlh_pkg::slot_t                     tail,
    output logic                                res_valid,
    output logic                                res_hit,
    output logic [rdlh_pkg::LEVEL_W_OUT-1:0]    res_level,
    output logic [rdlh_pkg::CNT_W-1:0]          res_count,
    output logic [rdlh_pkg::CNT_W-1:0]          res_unique
);
    import rdlh_pkg::*;

    cnt_t hist_reg [NUM_BUCKETS];
    cnt_t unique_reg;
    logic out_valid_reg;
    logic out_hit_reg;
    logic [LEVEL_W_OUT-1:0] out_level_reg;
    cnt_t out_count_reg;
    cnt_t out_unique_reg;

    lvl_t lvl;
    logic [7:0] lvl_ext;
    cnt_t bucket_next;
    cnt_t unique_next;

    assign lvl         = level_of(tail.pos);
    assign lvl_ext     = 8'(lvl);
    assign bucket_next = sat_inc(hist_reg[lvl]);
    assign unique_next = sat_inc(unique_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                hist_reg[b] <= '0;
            end
            unique_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_level_reg  <= '0;
            out_count_reg  <= '0;
            out_unique_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= tail.valid;
            if (tail.valid)
            begin
                if (tail.hit)
                begin
                    hist_reg[lvl]  <= bucket_next;
                    out_hit_reg    <= 1'b1;
                    out_level_reg  <= lvl_ext[LEVEL_W_OUT-1:0];
                    out_count_reg  <= bucket_next;
                    out_unique_reg <= unique_reg;
                end
                else
                begin
                    // cold line: count it, report zero level and count
                    unique_reg     <= unique_next;
                    out_hit_reg    <= 1'b0;
                    out_level_reg  <= '0;
                    out_count_reg  <= '0;
                    out_unique_reg <= unique_next;
                end
            end
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_hit    = out_hit_reg;
    assign res_level  = out_level_reg;
    assign res_count  = out_count_reg;
    assign res_unique = out_unique_reg;

endmodule

// ----- sv/reuse_distance_log2_histogram_core.sv -----
// LRU stack-distance profiler: each address transfer is reduced to a line tag
// (address >> block_shift) and pushed through a row of STACK_DEPTH cells, one
// cell per cycle while the row advances; the cells search and reorder the
// recency stack on the way. A new address is taken every cycle while the row
// advances. Its result passes, in order, through one slot register per cell
// of the row, the first loaded at the transfer edge, then the result register.
// The whole row holds while a result waits on out_ready. block_shift is
// applied when an address is taken; write it only with nothing in flight.
// Depends on rdlh_pkg, rdlh_stack (rdlh_cell) and rdlh_tally.
module reuse_distance_log2_histogram_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rdlh_pkg::SHIFT_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rdlh_pkg::ADDR_BITS-1:0]      address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_hit,
    output logic [rdlh_pkg::LEVEL_W_OUT-1:0]    reuse_bucket,
    output logic [rdlh_pkg::CNT_W-1:0]          bucket_count,
    output logic [rdlh_pkg::CNT_W-1:0]          unique_lines
);
    import rdlh_pkg::*;

    logic [SHIFT_W-1:0] block_shift_reg;
    logic  advance;
    slot_t head;
    slot_t tail;
    tag_t  tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            block_shift_reg <= cfg_wdata;
        end
    end

    // advance the row when the result register is free or being drained
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign tag = address >> block_shift_reg;

    always_comb
    begin
        head             = '0;
        head.valid       = in_valid;
        head.search_tag  = tag;
        head.carry_tag   = tag;
        head.carry_valid = 1'b1;
        head.hit         = 1'b0;
        head.pos         = '0;
    end

    rdlh_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .head    (head),
        .tail    (tail)
    );

    rdlh_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .tail       (tail),
        .res_valid  (out_valid),
        .res_hit    (is_hit),
        .res_level  (reuse_bucket),
        .res_count  (bucket_count),
        .res_unique (unique_lines)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for reuse_distance_log2_histogram_core: a directed table, then random
// address phases under several line sizes, checked against an LRU recency stack predictor.
// Depends on rdlh_pkg and the core RTL.
module tb;

    import rdlh_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SQUEEZE_CYCLES = 1600;
    localparam int SETTLE_CYCLES  = STACK_DEPTH + 32;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int HISTORY_DEPTH  = 4096;

    typedef enum logic {ROW_ACCESS, ROW_SHIFT} row_kind_t;

    typedef struct packed {
        logic                   hit;
        logic [LEVEL_W_OUT-1:0] level;
        cnt_t                   count;
        cnt_t                   lines;
    } access_result_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [ADDR_BITS-1:0] value;
        logic                 typed;
        access_result_t       want;
    } table_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [SHIFT_W-1:0]     cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    logic [ADDR_BITS-1:0]   address   = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   is_hit;
    logic [LEVEL_W_OUT-1:0] reuse_bucket;
    cnt_t                   bucket_count;
    cnt_t                   unique_lines;

    // predictor state: index 0 of the stack is the most recent line
    tag_t                   recency_stack[$];
    cnt_t                   level_hist[NUM_BUCKETS];
    cnt_t                   cold_lines;
    logic [SHIFT_W-1:0]     line_shift;

    access_result_t         expected_q[$];
    logic [ADDR_BITS-1:0]   issued_addr[$];
    table_row_t             steps[$];

    int                     mismatches  = 0;
    int                     cycle_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    bit                     squeeze_go   = 1'b0;
    bit                     squeeze_done = 1'b0;

    always #5 clk = ~clk;

    reuse_distance_log2_histogram_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_hit       (is_hit),
        .reuse_bucket (reuse_bucket),
        .bucket_count (bucket_count),
        .unique_lines (unique_lines)
    );

    task automatic profile_access(input logic [ADDR_BITS-1:0] a, output access_result_t r);
        tag_t tag;
        int   pos;
        int   lvl;
        int   p;
        tag = a >> line_shift;
        pos = -1;
        for (int i = 0; i < recency_stack.size(); i++)
        begin
            if (pos < 0 && recency_stack[i] == tag)
            begin
                pos = i;
            end
        end
        if (pos >= 0)
        begin
            // level is the bit length of the stack position
            lvl = 0;
            p   = pos;
            while (p != 0)
            begin
                lvl++;
                p = p >> 1;
            end
            if (lvl > NUM_BUCKETS - 1)
            begin
                lvl = NUM_BUCKETS - 1;
            end
            if (level_hist[lvl] != CNT_MAX)
            begin
                level_hist[lvl] += 1;
            end
            recency_stack.delete(pos);
            recency_stack.push_front(tag);
            r.hit   = 1'b1;
            r.level = LEVEL_W_OUT'(lvl);
            r.count = level_hist[lvl];
        end
        else
        begin
            recency_stack.push_front(tag);
            // drop the least recent line once the stack overflows
            if (recency_stack.size() > STACK_DEPTH)
            begin
                void'(recency_stack.pop_back());
            end
            if (cold_lines != CNT_MAX)
            begin
                cold_lines += 1;
            end
            r.hit   = 1'b0;
            r.level = '0;
            r.count = '0;
        end
        r.lines = cold_lines;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [ADDR_BITS-1:0] value,
                           input logic typed, input logic hit,
                           input logic [LEVEL_W_OUT-1:0] level, input cnt_t count,
                           input cnt_t lines);
        table_row_t row;
        row.kind       = kind;
        row.value      = value;
        row.typed      = typed;
        row.want.hit   = hit;
        row.want.level = level;
        row.want.count = count;
        row.want.lines = lines;
        steps = {steps, row};
    endtask

    task automatic send_access(input logic [ADDR_BITS-1:0] a, input logic typed,
                               input access_result_t want);
        access_result_t predicted;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        // transfer taken at this edge
        profile_access(a, predicted);
        expected_q = {expected_q, (typed ? want : predicted)};
        issued_addr = {issued_addr, a};
        if (issued_addr.size() > HISTORY_DEPTH)
        begin
            void'(issued_addr.pop_front());
        end
    endtask

    task automatic set_line_shift(input logic [SHIFT_W-1:0] v);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        line_shift = v;
    endtask

    // Mostly fresh lines; the rest revisit the last line or an earlier one at a
    // log-spread distance, with random offset bits inside the line.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] offset_mask;
        logic [ADDR_BITS-1:0] base;
        int                   roll;
        int                   k;
        int                   span;
        offset_mask = (ADDR_BITS'(1) << line_shift) - ADDR_BITS'(1);
        roll = $urandom_range(0, 99);
        if (issued_addr.size() == 0 || roll < 70)
        begin
            return ADDR_BITS'({$urandom, $urandom});
        end
        if (roll < 76)
        begin
            base = issued_addr[issued_addr.size() - 1];
        end
        else
        begin
            k    = $urandom_range(0, 11);
            span = $urandom_range((2 << k) - 2, (1 << k) - 1);
            if (span >= issued_addr.size())
            begin
                span = issued_addr.size() - 1;
            end
            base = issued_addr[issued_addr.size() - 1 - span];
        end
        return base ^ (ADDR_BITS'({$urandom, $urandom}) & offset_mask);
    endfunction

    initial
    begin
        logic [SHIFT_W-1:0] phase_shift[4];
        int                 phase_items[4];
        int                 n;
        int                 total;

        line_shift = SHIFT_RESET;
        cold_lines = '0;
        foreach (level_hist[i])
        begin
            level_hist[i] = '0;
        end

        // after reset the line size is 64 bytes
        add_row(ROW_ACCESS, 48'h0000_0000_0000, 1'b1, 1'b0, 0, 0, 1);
        add_row(ROW_ACCESS, 48'h0000_0000_003F, 1'b1, 1'b1, 0, 1, 1);
        add_row(ROW_ACCESS, 48'h0000_0000_0040, 1'b1, 1'b0, 0, 0, 2);
        add_row(ROW_ACCESS, 48'h0000_0000_0000, 1'b1, 1'b1, 1, 1, 2);
        add_row(ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 0, 0, 3);
        add_row(ROW_ACCESS, 48'hFFFF_FFFF_FFC0, 1'b1, 1'b1, 0, 2, 3);
        add_row(ROW_ACCESS, 48'h0000_0000_0040, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h5555_5555_5555, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_SHIFT,  48'd0,              1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_0000, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_0001, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_0000, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_SHIFT,  48'd15,             1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_7FFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_8000, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_SHIFT,  48'd13,             1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0000_0000_3FFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_SHIFT,  48'd12,             1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0ABC_DEF0_1FFF, 1'b0, 1'b0, 0, 0, 0);
        add_row(ROW_ACCESS, 48'h0ABC_DEF0_1000, 1'b0, 1'b0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 4;
        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_SHIFT)
            begin
                set_line_shift(steps[i].value[SHIFT_W-1:0]);
            end
            else
            begin
                send_access(steps[i].value, steps[i].typed, steps[i].want);
            end
        end

        phase_shift[0] = 4'd0;
        phase_shift[1] = 4'd15;
        phase_shift[2] = 4'd12;
        phase_shift[3] = SHIFT_W'($urandom_range(1, 11));
        phase_items[0] = 500;
        phase_items[1] = 200;
        phase_items[2] = 150;
        phase_items[3] = 250;
        total = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_line_shift(phase_shift[ph]);
            // stall the output long enough to fill the stack row and back up the input
            if (ph == 0)
            begin
                squeeze_go = 1'b1;
            end
            n = 0;
            while (n < phase_items[ph] || (ph == 3 && total < RANDOM_ITEMS))
            begin
                if (n % 64 == 0)
                begin
                    if (ph == 3)
                    begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                    else if (ph == 0)
                    begin
                        // pace the sender so it still offers when the row backs up
                        tx_idle_pct = 40;
                        rx_idle_pct = 4 * $urandom_range(0, 2);
                    end
                    else
                    begin
                        tx_idle_pct = 20 * $urandom_range(0, 2);
                        rx_idle_pct = 4 * $urandom_range(0, 2);
                    end
                end
                send_access(pick_address(), 1'b0, '0);
                n++;
                total++;
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("reuse_distance_log2_histogram_core test passed");
        end
        else
        begin
            $display("reuse_distance_log2_histogram_core test failed");
        end
        $finish;
    end

    // result side: random stall bursts plus one long hold-off
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (squeeze_go && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, %s=%0d %s=%0d %s=%0d %s=%0d",
                         $time, "got hit", is_hit, "level", reuse_bucket,
                         "count", bucket_count, "lines", unique_lines);
            end
            else
            begin
                want = expected_q.pop_front();
                if (is_hit !== want.hit)
                begin
                    mismatches++;
                    $display("%0t: is_hit expected %0d, got %0d", $time, want.hit, is_hit);
                end
                if (reuse_bucket !== want.level)
                begin
                    mismatches++;
                    $display("%0t: reuse_bucket expected %0d, got %0d",
                             $time, want.level, reuse_bucket);
                end
                if (bucket_count !== want.count)
                begin
                    mismatches++;
                    $display("%0t: bucket_count expected %0d, got %0d",
                             $time, want.count, bucket_count);
                end
                if (unique_lines !== want.lines)
                begin
                    mismatches++;
                    $display("%0t: unique_lines expected %0d, got %0d",
                             $time, want.lines, unique_lines);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("reuse_distance_log2_histogram_core test failed");
            $finish;
        end
    end

endmodule
